/* hdl/efp_pkg.sv */
// Shared constants, register codes and interface types for the escape-time fractal pixel block.
`default_nettype none

package efp_pkg;

    // Fixed-point format of all complex values.
    localparam int FRAC_BITS        = 28;
    localparam int MAX_EXPONENT_DEF = 8;
    localparam int SQUARE_EXP       = 2;

    localparam int VAL_W   = 64;
    localparam int COORD_W = 32;
    localparam int PIX_W   = 16;
    localparam int ITER_W  = 16;
    localparam int MODE_W  = 2;
    localparam int EXP_W   = 4;
    localparam int LIMIT_W = 31;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Internal values saturate to +/- (2^62 - 1).
    localparam logic signed [VAL_W-1:0] SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] FIX_ONE = 64'sd1 <<< FRAC_BITS;

    // Operating modes; the unused code behaves as the test pattern.
    localparam logic [MODE_W-1:0] MODE_TEST   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POWER  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_REAL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_IMAG    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_LIMIT   = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] corner_real;
        logic signed [COORD_W-1:0] corner_imag;
        logic signed [COORD_W-1:0] step_real;
        logic signed [COORD_W-1:0] step_imag;
        logic [ITER_W-1:0]         max_iterations;
        logic [MODE_W-1:0]         mode;
        logic [EXP_W-1:0]          exponent;
        logic [LIMIT_W-1:0]        escape_limit;
    } efp_cfg_t;

    localparam efp_cfg_t CFG_RESET = '{
        corner_real:    32'shE000_0000,
        corner_imag:    32'shE000_0000,
        step_real:      32'sd52429,
        step_imag:      32'sd69905,
        max_iterations: 16'd100,
        mode:           MODE_SQUARE,
        exponent:       4'd2,
        escape_limit:   31'd536870912
    };

    // Request to and response from the shared fixed-point multiplier.
    typedef struct packed {
        logic                     start;
        logic signed [VAL_W-1:0]  op_a;
        logic signed [VAL_W-1:0]  op_b;
    } fmul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [VAL_W-1:0]  product;
    } fmul_rsp_t;

endpackage

`default_nettype wire

/* hdl/efp_fmul.sv */
// Shared multi-cycle fixed-point multiplier built from four 32x32 partial products.
`default_nettype none

module efp_fmul import efp_pkg::*; (
    input  wire            clk,
    input  wire            rst_n,
    input  wire fmul_req_t req,
    output fmul_rsp_t      rsp
);

    localparam int HALF_W = VAL_W / 2;
    localparam int ACC_W  = 2 * VAL_W;
    localparam int CNT_W  = 3;
    localparam logic [CNT_W-1:0] PP_LAST  = 3'd3;
    localparam logic [CNT_W-1:0] ACC_LAST = 3'd4;
    localparam logic [CNT_W-1:0] FIN_STEP = 3'd5;

    logic                     busy_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     done_reg;
    logic [VAL_W-1:0]         ma_reg;
    logic [VAL_W-1:0]         mb_reg;
    logic                     neg_reg;
    logic [VAL_W-1:0]         pp_reg;
    logic [1:0]               pp_idx_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic signed [VAL_W-1:0]  prod_reg;

    logic [VAL_W-1:0]         abs_a;
    logic [VAL_W-1:0]         abs_b;
    logic [HALF_W-1:0]        half_a;
    logic [HALF_W-1:0]        half_b;
    logic [VAL_W-1:0]         pp_next;
    logic [ACC_W-1:0]         pp_shift;
    logic [ACC_W-1:0]         scaled;
    logic signed [VAL_W-1:0]  mag_sat;
    logic signed [VAL_W-1:0]  prod_next;

    assign abs_a = req.op_a[VAL_W-1] ? VAL_W'(-req.op_a) : VAL_W'(req.op_a);
    assign abs_b = req.op_b[VAL_W-1] ? VAL_W'(-req.op_b) : VAL_W'(req.op_b);

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                half_a = ma_reg[HALF_W-1:0];
                half_b = mb_reg[HALF_W-1:0];
            end
            2'd1:
            begin
                half_a = ma_reg[HALF_W-1:0];
                half_b = mb_reg[VAL_W-1:HALF_W];
            end
            2'd2:
            begin
                half_a = ma_reg[VAL_W-1:HALF_W];
                half_b = mb_reg[HALF_W-1:0];
            end
            default:
            begin
                half_a = ma_reg[VAL_W-1:HALF_W];
                half_b = mb_reg[VAL_W-1:HALF_W];
            end
        endcase
    end

    assign pp_next = half_a * half_b;

    // Cross terms sit one half-word up, the high term a whole word up.
    always_comb
    begin
        case (pp_idx_reg)
            2'd0:    pp_shift = {{VAL_W{1'b0}}, pp_reg};
            2'd1,
            2'd2:    pp_shift = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            default: pp_shift = {pp_reg, {VAL_W{1'b0}}};
        endcase
    end

    // The magnitude is truncated, saturated, and only then signed.
    assign scaled    = acc_reg >> FRAC_BITS;
    assign mag_sat   = (|scaled[ACC_W-1:VAL_W-2]) ? SAT_LIM
                                                  : $signed({2'b00, scaled[VAL_W-3:0]});
    assign prod_next = neg_reg ? -mag_sat : mag_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == FIN_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ma_reg  <= abs_a;
            mb_reg  <= abs_b;
            neg_reg <= req.op_a[VAL_W-1] ^ req.op_b[VAL_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg <= PP_LAST)
            begin
                pp_reg     <= pp_next;
                pp_idx_reg <= cnt_reg[1:0];
            end
            if (cnt_reg != '0 && cnt_reg <= ACC_LAST)
            begin
                acc_reg <= acc_reg + pp_shift;
            end
            if (cnt_reg == FIN_STEP)
            begin
                prod_reg <= prod_next;
            end
        end
    end

    assign rsp = '{done: done_reg, product: prod_reg};

    a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiplier started while a product is in progress");

    a_done_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("multiplier done held longer than one cycle");

    a_product_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (prod_reg <= SAT_LIM && prod_reg >= -SAT_LIM))
        else $error("multiplier product outside the saturation range");

endmodule

`default_nettype wire

/* hdl/efp_seq.sv */
// Iteration sequencer: forms c, raises z to the power, subtracts c and tests for escape.
`default_nettype none

module efp_seq import efp_pkg::*; #(
    parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire efp_cfg_t     cfg,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire [PIX_W-1:0]   pixel_x,
    input  wire [PIX_W-1:0]   pixel_y,
    output logic              res_valid,
    input  wire               res_ready,
    output logic [ITER_W-1:0] res_count,
    output fmul_req_t         req,
    input  wire fmul_rsp_t    rsp
);

    localparam int K_W = $clog2(MAX_EXPONENT + 1);
    localparam int CPROD_W = PIX_W + 1 + COORD_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CRE  = 8'b0000_0010,
        S_CIM  = 8'b0000_0100,
        S_ITER = 8'b0000_1000,
        S_POW  = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_WAIT = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    // Which real product the multiplier is working on.
    typedef enum logic [2:0] {
        T_RR = 3'd0,
        T_II = 3'd1,
        T_RI = 3'd2,
        T_IR = 3'd3,
        T_ZR = 3'd4,
        T_ZI = 3'd5
    } term_t;

    state_t                  state_reg, state_next;
    term_t                   term_reg, term_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    logic [K_W-1:0]          j_reg, j_next;
    logic [K_W-1:0]          k_reg, k_next;
    logic [PIX_W-1:0]        px_reg, px_next;
    logic [PIX_W-1:0]        py_reg, py_next;
    logic signed [VAL_W-1:0] c_re_reg, c_re_next;
    logic signed [VAL_W-1:0] c_im_reg, c_im_next;
    logic signed [VAL_W-1:0] z_re_reg, z_re_next;
    logic signed [VAL_W-1:0] z_im_reg, z_im_next;
    logic signed [VAL_W-1:0] p_re_reg, p_re_next;
    logic signed [VAL_W-1:0] p_im_reg, p_im_next;
    logic signed [VAL_W-1:0] tmp_re_reg, tmp_re_next;
    logic signed [VAL_W-1:0] acc_reg, acc_next;
    logic [ITER_W-1:0]       res_reg, res_next;

    logic [K_W-1:0]            k_sel;
    logic [7:0]                pat_prod;
    logic [PIX_W-1:0]          pix_sel;
    logic signed [COORD_W-1:0] step_sel;
    logic signed [COORD_W-1:0] corner_sel;
    logic signed [CPROD_W-1:0] cprod;
    logic signed [VAL_W-1:0]   coord;
    logic signed [VAL_W-1:0]   mag;
    logic signed [VAL_W-1:0]   limit_ext;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        r = v;
        if (v > SAT_LIM)
            r = SAT_LIM;
        else if (v < -SAT_LIM)
            r = -SAT_LIM;
        return r;
    endfunction

    always_comb
    begin
        if (cfg.mode == MODE_SQUARE)
            k_sel = K_W'(SQUARE_EXP);
        else if (int'(cfg.exponent) > MAX_EXPONENT)
            k_sel = K_W'(MAX_EXPONENT);
        else
            k_sel = K_W'(cfg.exponent);
    end

    // Only the low byte of the test pattern product is kept.
    assign pat_prod = 8'(pixel_x[7:0] * pixel_y[7:0]);

    // One small multiplier forms both coordinates, real part first.
    assign pix_sel    = (state_reg == S_CRE) ? px_reg : py_reg;
    assign step_sel   = (state_reg == S_CRE) ? cfg.step_real : cfg.step_imag;
    assign corner_sel = (state_reg == S_CRE) ? cfg.corner_real : cfg.corner_imag;
    assign cprod      = $signed({1'b0, pix_sel}) * step_sel;
    assign coord      = sat_val(VAL_W'(corner_sel) + VAL_W'(cprod));

    assign mag       = sat_val(acc_reg + rsp.product);
    assign limit_ext = $signed({{(VAL_W-LIMIT_W){1'b0}}, cfg.escape_limit});

    always_comb
    begin
        req.start = (state_reg == S_MUL);
        case (term_reg)
            T_RR:
            begin
                req.op_a = p_re_reg;
                req.op_b = z_re_reg;
            end
            T_II:
            begin
                req.op_a = p_im_reg;
                req.op_b = z_im_reg;
            end
            T_RI:
            begin
                req.op_a = p_re_reg;
                req.op_b = z_im_reg;
            end
            T_IR:
            begin
                req.op_a = p_im_reg;
                req.op_b = z_re_reg;
            end
            T_ZR:
            begin
                req.op_a = z_re_reg;
                req.op_b = z_re_reg;
            end
            default:
            begin
                req.op_a = z_im_reg;
                req.op_b = z_im_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        term_next   = term_reg;
        iter_next   = iter_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        c_re_next   = c_re_reg;
        c_im_next   = c_im_reg;
        z_re_next   = z_re_reg;
        z_im_next   = z_im_reg;
        p_re_next   = p_re_reg;
        p_im_next   = p_im_reg;
        tmp_re_next = tmp_re_reg;
        acc_next    = acc_reg;
        res_next    = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    px_next = pixel_x;
                    py_next = pixel_y;
                    if (cfg.mode == MODE_SQUARE || cfg.mode == MODE_POWER)
                    begin
                        k_next     = k_sel;
                        iter_next  = '0;
                        z_re_next  = '0;
                        z_im_next  = '0;
                        state_next = S_CRE;
                    end
                    else
                    begin
                        res_next   = {{(ITER_W-8){1'b0}}, pat_prod};
                        state_next = S_DONE;
                    end
                end
            end
            S_CRE:
            begin
                c_re_next  = coord;
                state_next = S_CIM;
            end
            S_CIM:
            begin
                c_im_next  = coord;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                if (iter_reg == cfg.max_iterations)
                begin
                    res_next   = iter_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    p_re_next  = FIX_ONE;
                    p_im_next  = '0;
                    j_next     = '0;
                    state_next = S_POW;
                end
            end
            S_POW:
            begin
                if (j_reg == k_reg)
                begin
                    z_re_next = sat_val(p_re_reg - c_re_reg);
                    z_im_next = sat_val(p_im_reg - c_im_reg);
                    term_next = T_ZR;
                end
                else
                begin
                    term_next = T_RR;
                end
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (rsp.done)
                begin
                    case (term_reg)
                        T_RR:
                        begin
                            acc_next   = rsp.product;
                            term_next  = T_II;
                            state_next = S_MUL;
                        end
                        T_II:
                        begin
                            tmp_re_next = sat_val(acc_reg - rsp.product);
                            term_next   = T_RI;
                            state_next  = S_MUL;
                        end
                        T_RI:
                        begin
                            acc_next   = rsp.product;
                            term_next  = T_IR;
                            state_next = S_MUL;
                        end
                        T_IR:
                        begin
                            p_re_next  = tmp_re_reg;
                            p_im_next  = sat_val(acc_reg + rsp.product);
                            j_next     = j_reg + K_W'(1);
                            state_next = S_POW;
                        end
                        T_ZR:
                        begin
                            acc_next   = rsp.product;
                            term_next  = T_ZI;
                            state_next = S_MUL;
                        end
                        T_ZI:
                        begin
                            if (mag >= limit_ext)
                            begin
                                res_next   = iter_reg;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                iter_next  = iter_reg + ITER_W'(1);
                                state_next = S_ITER;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg  <= T_RR;
            iter_reg  <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            iter_reg  <= iter_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        c_re_reg   <= c_re_next;
        c_im_reg   <= c_im_next;
        z_re_reg   <= z_re_next;
        z_im_reg   <= z_im_next;
        p_re_reg   <= p_re_next;
        p_im_reg   <= p_im_next;
        tmp_re_reg <= tmp_re_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_count = res_reg;

    a_iter_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ITER || state_reg == S_POW || state_reg == S_MUL
         || state_reg == S_WAIT) |-> iter_reg <= cfg.max_iterations)
        else $error("iteration count ran past the limit");

    a_start_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> state_reg == S_WAIT)
        else $error("multiplier started without waiting for its product");

    a_power_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POW |-> j_reg <= k_reg)
        else $error("power step count exceeded the exponent");

endmodule

`default_nettype wire

/* hdl/escape_time_fractal_pixel.sv */
// Top level: configuration registers, sequencer, shared multiplier and output register.
// Each iteration of a pixel needs 4 * k + 2 real products from the shared multiplier, where k
// is the exponent in use (2 in square mode). A new pixel is taken once the previous result
// has moved into the output register. Reset is asynchronous and active low; it restores the
// register defaults and empties the pipeline.
`default_nettype none

module escape_time_fractal_pixel import efp_pkg::*; #(
    parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire [31:0]          s_axis_tdata,   // pixel_x [15:0], pixel_y [31:16]
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // iteration_count [15:0]
    input  wire                 cfg_wr_en,
    input  wire [CFG_IDX_W-1:0] cfg_index,
    input  wire [CFG_W-1:0]     cfg_data
);

    efp_cfg_t          cfg_reg;
    fmul_req_t         mul_req;
    fmul_rsp_t         mul_rsp;
    logic              res_valid;
    logic              res_ready;
    logic [ITER_W-1:0] res_count;
    logic              m_valid_reg;
    logic [ITER_W-1:0] m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CORNER_REAL:    cfg_reg.corner_real    <= $signed(cfg_data[COORD_W-1:0]);
                REG_CORNER_IMAG:    cfg_reg.corner_imag    <= $signed(cfg_data[COORD_W-1:0]);
                REG_STEP_REAL:      cfg_reg.step_real      <= $signed(cfg_data[COORD_W-1:0]);
                REG_STEP_IMAG:      cfg_reg.step_imag      <= $signed(cfg_data[COORD_W-1:0]);
                REG_MAX_ITERATIONS: cfg_reg.max_iterations <= cfg_data[ITER_W-1:0];
                REG_MODE:           cfg_reg.mode           <= cfg_data[MODE_W-1:0];
                REG_EXPONENT:       cfg_reg.exponent       <= cfg_data[EXP_W-1:0];
                REG_ESCAPE_LIMIT:   cfg_reg.escape_limit   <= cfg_data[LIMIT_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    efp_seq #(
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .pixel_x   (s_axis_tdata[PIX_W-1:0]),
        .pixel_y   (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_count (res_count),
        .req       (mul_req),
        .rsp       (mul_rsp)
    );

    efp_fmul u_fmul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // The output register frees the sequencer as soon as a result is parked here.
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            m_data_reg <= res_count;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the escape-time fractal pixel block: directed and random pixels.
module tb_top;
    import efp_pkg::*;

    // The spare mode code; the block treats it like the test pattern.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int ITEM_TARGET = 700;
    // Random frames bound the iteration work of a pixel by ITER_BUDGET, costed per factor of
    // z^k and per iteration, so that the run stays short.
    localparam int CYC_PER_FACTOR = 33;
    localparam int CYC_PER_ITER   = 18;
    localparam int ITER_BUDGET    = 1600;
    localparam int CYCLE_LIMIT    = 5_000_000;

    localparam logic signed [COORD_W-1:0] FIX_ONE_HALF_NEG = 32'shE800_0000;  // -1.5
    localparam logic signed [COORD_W-1:0] FIX_STEP_64TH    = 32'sh0040_0000;  // 1/64
    localparam logic [LIMIT_W-1:0]        FIX_TWO          = 31'h2000_0000;
    localparam logic [LIMIT_W-1:0]        FIX_FOUR         = 31'h4000_0000;

    typedef struct {
        longint re;
        longint im;
    } cplx_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;   // pixel_x [15:0], pixel_y [31:16]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;        // iteration_count [15:0]
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    efp_cfg_t          cfg_model = CFG_RESET;
    logic [ITER_W-1:0] count_queue[$];
    logic [ITER_W-1:0] want_count;
    int                error_count = 0;
    int                pixels_sent = 0;
    int unsigned       cycle_count = 0;
    bit                steady_flow = 1'b0;

    always #5 clk = ~clk;

    escape_time_fractal_pixel i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    function automatic longint clamp62(input longint v);
        if (v > SAT_LIM)
        begin
            return SAT_LIM;
        end
        if (v < -SAT_LIM)
        begin
            return -SAT_LIM;
        end
        return v;
    endfunction

    // Magnitudes are multiplied exactly, truncated toward zero, saturated, then signed.
    function automatic longint fx_mul(input longint a, input longint b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] full;
        logic [127:0] shr;
        longint       m;
        bit           neg;
        neg  = (a < 0) != (b < 0);
        ma   = (a < 0) ? -a : a;
        mb   = (b < 0) ? -b : b;
        full = {64'd0, ma} * {64'd0, mb};
        shr  = full >> FRAC_BITS;
        if (shr[127:62] != '0)
        begin
            m = SAT_LIM;
        end
        else
        begin
            m = longint'(shr[61:0]);
        end
        return neg ? -m : m;
    endfunction

    function automatic cplx_t cx_mul(input cplx_t p, input cplx_t q);
        cplx_t r;
        r.re = clamp62(fx_mul(p.re, q.re) - fx_mul(p.im, q.im));
        r.im = clamp62(fx_mul(p.re, q.im) + fx_mul(p.im, q.re));
        return r;
    endfunction

    function automatic logic [ITER_W-1:0] escape_count(input logic [PIX_W-1:0] px,
                                                       input logic [PIX_W-1:0] py);
        cplx_t       c;
        cplx_t       z;
        cplx_t       p;
        logic [31:0] prod;
        longint      mag;
        int          k;
        int          n;
        int          j;
        if (cfg_model.mode != MODE_SQUARE && cfg_model.mode != MODE_POWER)
        begin
            prod = px * py;
            return {8'd0, prod[7:0]};
        end
        if (cfg_model.mode == MODE_SQUARE)
        begin
            k = SQUARE_EXP;
        end
        else if (cfg_model.exponent > MAX_EXPONENT_DEF)
        begin
            k = MAX_EXPONENT_DEF;
        end
        else
        begin
            k = int'(cfg_model.exponent);
        end
        c.re = clamp62(longint'($signed(cfg_model.corner_real))
                       + longint'(px) * longint'($signed(cfg_model.step_real)));
        c.im = clamp62(longint'($signed(cfg_model.corner_imag))
                       + longint'(py) * longint'($signed(cfg_model.step_imag)));
        z.re = 0;
        z.im = 0;
        for (n = 0; n < cfg_model.max_iterations; n++)
        begin
            // z^k is built as 1 * z * z ... so that k = 0 gives exactly one.
            p.re = FIX_ONE;
            p.im = 0;
            for (j = 0; j < k; j++)
            begin
                p = cx_mul(p, z);
            end
            z.re = clamp62(p.re - c.re);
            z.im = clamp62(p.im - c.im);
            mag  = clamp62(fx_mul(z.re, z.re) + fx_mul(z.im, z.im));
            if (mag >= longint'(cfg_model.escape_limit))
            begin
                break;
            end
        end
        return ITER_W'(n);
    endfunction

    function automatic int pick_gap();
        int roll;
        if (steady_flow)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Picks one axis of a frame that covers roughly the interesting region, scanned
    // either upward or downward, with the span spread over 2^bits pixels.
    function automatic void frame_axis(input longint origin, input int bits,
                                       output logic signed [COORD_W-1:0] corner,
                                       output logic signed [COORD_W-1:0] stride);
        longint span;
        longint base;
        longint inc;
        span = (longint'(3) <<< FRAC_BITS) + longint'($urandom_range(0, 1 << FRAC_BITS));
        base = origin + longint'($urandom_range(0, 1 << (FRAC_BITS - 2)));
        inc  = span >>> bits;
        if ($urandom_range(0, 1) == 1)
        begin
            base = base + span;
            inc  = -inc;
        end
        corner = base[COORD_W-1:0];
        stride = inc[COORD_W-1:0];
    endfunction

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Only called with the block idle; every register is rewritten each time.
    task automatic load_config(input efp_cfg_t next);
        put_reg(REG_CORNER_REAL, next.corner_real);
        put_reg(REG_CORNER_IMAG, next.corner_imag);
        put_reg(REG_STEP_REAL, next.step_real);
        put_reg(REG_STEP_IMAG, next.step_imag);
        put_reg(REG_MAX_ITERATIONS, CFG_W'(next.max_iterations));
        put_reg(REG_MODE, CFG_W'(next.mode));
        put_reg(REG_EXPONENT, CFG_W'(next.exponent));
        put_reg(REG_ESCAPE_LIMIT, CFG_W'(next.escape_limit));
        cfg_wr_en <= 1'b0;
        cfg_model = next;
    endtask

    // Valid stays high after the transfer so that a following pixel with no gap
    // goes out back to back; whoever does something else lowers it first.
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        do
            @(posedge clk);
        while (!s_axis_tready);
        count_queue.push_back(escape_count(px, py));
        pixels_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (count_queue.size() != 0);
    endtask

    task automatic test_reset_defaults();
        send_pixel(16'd0, 16'd0);
        // Close to the origin: never escapes, so it runs the default 100 iterations.
        send_pixel(16'd10240, 16'd7680);
        send_pixel(16'hFFFF, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_pattern_mode();
        efp_cfg_t next;
        next = CFG_RESET;
        next.mode = MODE_TEST;
        load_config(next);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h00FF);
        send_pixel(16'h00AA, 16'h5555);
        wait_drained();
        next.mode = MODE_UNUSED;
        load_config(next);
        send_pixel(16'h8001, 16'h7FFE);
        send_pixel(16'h00FF, 16'h00FF);
        wait_drained();
    endtask

    task automatic test_square_limits();
        efp_cfg_t next;
        next = CFG_RESET;
        next.max_iterations = '0;
        load_config(next);
        send_pixel(16'd10240, 16'd7680);
        wait_drained();
        // A zero bound lets the first step escape even for a point inside the set.
        next.max_iterations = '1;
        next.escape_limit   = '0;
        load_config(next);
        send_pixel(16'd10240, 16'd7680);
        wait_drained();
        // Extreme corners and strides put every point far out, so the first step
        // escapes despite the huge limit; the far pixels saturate the magnitude.
        next.corner_real  = 32'sh7FFF_FFFF;
        next.corner_imag  = 32'sh8000_0000;
        next.step_real    = 32'sh7FFF_FFFF;
        next.step_imag    = 32'sh8000_0000;
        next.escape_limit = '1;
        load_config(next);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'd0);
        wait_drained();
    endtask

    task automatic test_power_exponents();
        efp_cfg_t    next;
        logic [EXP_W-1:0] exp_list[5] = '{4'd0, 4'd1, 4'd8, 4'd9, 4'd15};
        next = CFG_RESET;
        next.mode           = MODE_POWER;
        next.max_iterations = 16'd10;
        next.escape_limit   = FIX_FOUR;
        next.corner_real    = FIX_ONE_HALF_NEG;
        next.corner_imag    = FIX_ONE_HALF_NEG;
        next.step_real      = FIX_STEP_64TH;
        next.step_imag      = FIX_STEP_64TH;
        // The pixel sits at c = -0.25: bounded for most powers, a linear walk for
        // the first power, and a constant 1.25 for the zero power.
        foreach (exp_list[i])
        begin
            next.exponent = exp_list[i];
            load_config(next);
            send_pixel(16'd80, 16'd96);
            wait_drained();
        end
    endtask

    task automatic test_random_frames();
        efp_cfg_t         next;
        int               shape;
        int               k;
        int               bits;
        int               npix;
        int               roll;
        logic [PIX_W-1:0] pmask;
        while (pixels_sent < ITEM_TARGET)
        begin
            next = cfg_model;
            shape = $urandom_range(0, 99);
            next.exponent = EXP_W'($urandom_range(0, 15));
            if (shape < 10)
            begin
                next.mode = ($urandom_range(0, 1) == 1) ? MODE_TEST : MODE_UNUSED;
            end
            else if (shape < 55)
            begin
                next.mode = MODE_SQUARE;
            end
            else
            begin
                next.mode = MODE_POWER;
            end
            if (next.mode == MODE_SQUARE)
            begin
                k = SQUARE_EXP;
            end
            else if (next.exponent > MAX_EXPONENT_DEF)
            begin
                k = MAX_EXPONENT_DEF;
            end
            else
            begin
                k = int'(next.exponent);
            end
            if (next.mode == MODE_SQUARE || next.mode == MODE_POWER)
            begin
                next.max_iterations = ITER_W'($urandom_range(0,
                    ITER_BUDGET / (CYC_PER_FACTOR * k + CYC_PER_ITER)));
            end
            else
            begin
                next.max_iterations = ITER_W'($urandom);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                // Arbitrary geometry: mostly far-out points that escape at once.
                next.corner_real  = $urandom;
                next.corner_imag  = $urandom;
                next.step_real    = $urandom;
                next.step_imag    = $urandom;
                next.escape_limit = LIMIT_W'($urandom);
                bits = PIX_W;
            end
            else
            begin
                bits = $urandom_range(1, PIX_W);
                frame_axis(-(longint'(9) <<< (FRAC_BITS - 2)), bits,
                           next.corner_real, next.step_real);
                frame_axis(-(longint'(3) <<< (FRAC_BITS - 1)), bits,
                           next.corner_imag, next.step_imag);
                roll = $urandom_range(0, 2);
                if (roll == 0)
                begin
                    next.escape_limit = FIX_TWO;
                end
                else if (roll == 1)
                begin
                    next.escape_limit = FIX_FOUR;
                end
                else
                begin
                    next.escape_limit = LIMIT_W'($urandom);
                end
            end
            load_config(next);
            steady_flow = ($urandom_range(0, 3) == 0);
            npix  = $urandom_range(8, 40);
            pmask = PIX_W'((32'd1 << bits) - 1);
            repeat (npix)
            begin
                send_pixel(PIX_W'($urandom) & pmask, PIX_W'($urandom) & pmask);
                if ($urandom_range(0, 39) == 0)
                begin
                    wait_drained();
                end
            end
            wait_drained();
            steady_flow = 1'b0;
        end
    endtask

    // Result side: random back-pressure, mostly short, sometimes long; none in steady flow.
    initial
    begin : ready_pattern
        int run;
        int roll;
        @(posedge clk);
        forever
        begin
            if (steady_flow)
            begin
                m_axis_tready <= 1'b1;
                run = 1;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                begin
                    m_axis_tready <= 1'b1;
                    run = $urandom_range(1, 8);
                end
                else if (roll < 95)
                begin
                    m_axis_tready <= 1'b0;
                    run = $urandom_range(1, 3);
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    run = $urandom_range(20, 60);
                end
            end
            repeat (run) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (count_queue.size() == 0)
            begin
                $display("%0t: iteration_count transfer with none expected, actual %0d",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want_count = count_queue.pop_front();
                if (m_axis_tdata !== want_count)
                begin
                    $display("%0t: iteration_count mismatch, expected %0d, actual %0d",
                             $time, want_count, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, count_queue.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_pattern_mode();
        test_square_limits();
        test_power_exponents();
        test_random_frames();
        wait_drained();
        repeat (100) @(posedge clk);
        if (count_queue.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, count_queue.size());
        end
        if (error_count == 0 && count_queue.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/efp_pkg.sv
hdl/efp_fmul.sv
hdl/efp_seq.sv
hdl/escape_time_fractal_pixel.sv
dv/tb_top.sv
